// ===== rtl/otpt_pkg.sv =====
// Package for the one-shot / periodic timer table.
// Holds table size, function and status codes, and the entry and result records.
// Depends on nothing; imported by the timer table top level.
`timescale 1ns / 1ps
`default_nettype none

package otpt_pkg;

    // Slots per table, and derived index widths
    localparam int SLOTS     = 8;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W    = SLOT_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    // Field widths fixed by the stream format
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int OSLOT_W  = 3;
    localparam int TIME_W   = 32;

    // Function codes of an input beat
    localparam logic [FUNC_W-1:0] FN_TICK      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD_ONCE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ADD_EVERY = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REM_ONCE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REM_EVERY = 3'd4;

    // Status codes of a result beat
    localparam logic [STATUS_W-1:0] ST_ONCE_FIRED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EVERY_FIRED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd5;

    // Table selector: one-shot table at the low half of the RAM
    localparam logic TBL_ONCE  = 1'b0;
    localparam logic TBL_EVERY = 1'b1;

    // One RAM entry: period, start or reference time, fire count
    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] ref_ms;
        logic [TIME_W-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One result beat without its last flag
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OSLOT_W-1:0]  slot;
        logic [TIME_W-1:0]   elapsed;
        logic [TIME_W-1:0]   count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/otpt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module otpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/oneshot_periodic_timer_table_core.sv =====
// Top level of the one-shot / periodic timer table.
// Depends on otpt_pkg and otpt_ram (one RAM holds both tables).
//
// Usage:
//   Input stream (s_axis): tuser carries the function, tdata the period in ms.
//   A tick advances the 32-bit ms counter and scans the one-shot slots, then
//   the periodic slots, one slot per cycle out of the entry RAM. Every expired
//   timer gives one fire beat; a tick with nothing expired gives no beat.
//   Add gives one beat (added or full); remove gives one beat (removed or
//   not found). The final beat of each input beat carries tlast.
//   Throughput: one input beat at a time. A tick reads every slot of both
//   tables through the single RAM read port; a remove reads the slots of one
//   table until the first match; an add reads no slot.
//   A result beat passes the pending register, then the output register; for
//   a remove or a tick the RAM read comes before them.
//   Output stream (m_axis) has an output register; a new input beat is taken
//   while a finished result still waits there. When the receiver stalls, the
//   scan holds at the slot whose result cannot be placed.
//   Reset (i_rst_n, synchronous, active low) clears the ms counter and all
//   slot valid bits; entry RAM contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module oneshot_periodic_timer_table_core
    import otpt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input beats
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] period_ms
    input  wire logic [2:0]  s_axis_tuser,  // [2:0] func
    // Result beats
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // [2:0] slot, [34:3] elapsed_ms,
                                            // [66:35] fire_count, [71:67] zero
    output logic [2:0]       m_axis_tuser,  // [2:0] status
    output logic             m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    // Control and payload registers
    t_state                   r_state, n_state;
    logic [FUNC_W-1:0]        r_func, n_func;
    logic [TIME_W-1:0]        r_p, n_p;
    logic [TIME_W-1:0]        r_now, n_now;
    logic [1:0][SLOTS-1:0]    r_vld, n_vld;
    logic                     r_rd_type, n_rd_type;
    logic [SLOT_W-1:0]        r_rd_slot, n_rd_slot;
    logic                     r_rd_more, n_rd_more;
    logic                     r_ev_vld, n_ev_vld;
    logic                     r_ev_type, n_ev_type;
    logic [SLOT_W-1:0]        r_ev_slot, n_ev_slot;
    logic                     r_pend_vld, n_pend_vld;
    t_result                  r_pend, n_pend;
    logic                     r_out_vld, n_out_vld;
    t_result                  r_out, n_out;
    logic                     r_out_last, n_out_last;

    // Combinational helpers
    logic                     in_acc;
    logic                     out_free;
    logic                     is_tick;
    logic                     add_type;
    logic                     free_found;
    logic [SLOT_W-1:0]        free_idx;
    t_entry                   rd_ent;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic [TIME_W-1:0]        ev_el;
    logic [TIME_W-1:0]        ev_cnt;
    logic                     ev_live;
    logic                     ev_fire;
    logic                     ev_match;
    logic                     adv;
    logic                     push;
    logic                     push_last;
    t_result                  push_res;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    t_entry                   ram_wdata;
    logic                     ram_re;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign is_tick       = (r_func == FN_TICK);
    assign add_type      = (s_axis_tuser == FN_ADD_EVERY) ? TBL_EVERY : TBL_ONCE;

    // Find the lowest free slot of the table an add goes to
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_vld[add_type][i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Evaluate the entry that the RAM returned
    assign rd_ent   = t_entry'(ram_rdata);
    assign ev_live  = r_vld[r_ev_type][r_ev_slot];
    assign ev_el    = r_now - rd_ent.ref_ms;
    assign ev_cnt   = rd_ent.count + 32'd1;
    assign ev_fire  = ev_live && (ev_el >= rd_ent.period);
    assign ev_match = ev_live && (rd_ent.period == r_p);

    // Hold the scan when a fire must push a pending beat that has no room
    assign adv = !r_ev_vld || !is_tick || !ev_fire || !r_pend_vld || out_free;

    // Read next slot, write back a restarted periodic timer or a new entry
    assign ram_re = (r_state == S_SCAN) && r_rd_more && adv;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {r_ev_type, r_ev_slot};
        ram_wdata = '{period: rd_ent.period, ref_ms: r_now, count: ev_cnt};
        if (r_state == S_IDLE) begin
            ram_we    = in_acc && free_found &&
                        ((s_axis_tuser == FN_ADD_ONCE) || (s_axis_tuser == FN_ADD_EVERY));
            ram_waddr = {add_type, free_idx};
            ram_wdata = '{period: s_axis_tdata, ref_ms: r_now, count: '0};
        end else if (r_state == S_SCAN) begin
            ram_we = r_ev_vld && is_tick && ev_fire && adv && (r_ev_type == TBL_EVERY);
        end
    end

    otpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr ({r_rd_type, r_rd_slot}),
        .o_rdata (ram_rdata)
    );

    // Next-state logic
    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_p        = r_p;
        n_now      = r_now;
        n_vld      = r_vld;
        n_rd_type  = r_rd_type;
        n_rd_slot  = r_rd_slot;
        n_rd_more  = r_rd_more;
        n_ev_vld   = r_ev_vld;
        n_ev_type  = r_ev_type;
        n_ev_slot  = r_ev_slot;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        push       = 1'b0;
        push_last  = 1'b0;
        push_res   = r_pend;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func    = s_axis_tuser;
                    n_p       = s_axis_tdata;
                    n_rd_slot = '0;
                    n_rd_more = 1'b1;
                    n_ev_vld  = 1'b0;
                    case (s_axis_tuser)
                        FN_TICK: begin
                            n_now     = r_now + 32'd1;
                            n_rd_type = TBL_ONCE;
                            n_state   = S_SCAN;
                        end
                        FN_ADD_ONCE, FN_ADD_EVERY: begin
                            n_pend_vld = 1'b1;
                            n_pend     = '{status: ST_FULL, slot: '0, elapsed: '0, count: '0};
                            if (free_found) begin
                                n_vld[add_type][free_idx] = 1'b1;
                                n_pend.status = ST_ADDED;
                                n_pend.slot   = OSLOT_W'(free_idx);
                            end
                            n_state = S_FLUSH;
                        end
                        FN_REM_ONCE: begin
                            n_rd_type = TBL_ONCE;
                            n_state   = S_SCAN;
                        end
                        FN_REM_EVERY: begin
                            n_rd_type = TBL_EVERY;
                            n_state   = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Advance the read pointer over the slots in order
                if (adv) begin
                    if (r_rd_more) begin
                        n_ev_vld  = 1'b1;
                        n_ev_type = r_rd_type;
                        n_ev_slot = r_rd_slot;
                        if (r_rd_slot == SLOT_W'(SLOTS - 1)) begin
                            n_rd_slot = '0;
                            if (is_tick && (r_rd_type == TBL_ONCE)) begin
                                n_rd_type = TBL_EVERY;
                            end else begin
                                n_rd_more = 1'b0;
                            end
                        end else begin
                            n_rd_slot = r_rd_slot + SLOT_W'(1);
                        end
                    end else begin
                        n_ev_vld = 1'b0;
                    end
                end

                // Fire: free or restart the slot, keep the beat pending
                if (r_ev_vld && is_tick && ev_fire && adv) begin
                    if (r_pend_vld) begin
                        push = 1'b1;
                    end
                    n_pend_vld      = 1'b1;
                    n_pend.slot     = OSLOT_W'(r_ev_slot);
                    n_pend.elapsed  = ev_el;
                    if (r_ev_type == TBL_ONCE) begin
                        n_vld[TBL_ONCE][r_ev_slot] = 1'b0;
                        n_pend.status = ST_ONCE_FIRED;
                        n_pend.count  = '0;
                    end else begin
                        n_pend.status = ST_EVERY_FIRED;
                        n_pend.count  = ev_cnt;
                    end
                end

                // Remove: stop at the first live slot of that period
                if (r_ev_vld && !is_tick && ev_match) begin
                    n_vld[r_ev_type][r_ev_slot] = 1'b0;
                    n_pend_vld = 1'b1;
                    n_pend     = '{status: ST_REMOVED, slot: OSLOT_W'(r_ev_slot),
                                   elapsed: '0, count: '0};
                    n_ev_vld   = 1'b0;
                    n_rd_more  = 1'b0;
                    n_state    = S_FLUSH;
                end

                // End of the walk
                if (!r_rd_more && !r_ev_vld) begin
                    if (is_tick) begin
                        n_state = r_pend_vld ? S_FLUSH : S_IDLE;
                    end else begin
                        n_pend_vld = 1'b1;
                        n_pend     = '{status: ST_NOT_FOUND, slot: '0, elapsed: '0, count: '0};
                        n_state    = S_FLUSH;
                    end
                end
            end

            S_FLUSH: begin
                // Drop the final beat into the output register
                if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Output register
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_out_last = r_out_last;
        if (push) begin
            n_out_vld  = 1'b1;
            n_out      = push_res;
            n_out_last = push_last;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_now      <= '0;
            r_vld      <= '0;
            r_rd_more  <= 1'b0;
            r_ev_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_now      <= n_now;
            r_vld      <= n_vld;
            r_rd_more  <= n_rd_more;
            r_ev_vld   <= n_ev_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
        r_func     <= n_func;
        r_p        <= n_p;
        r_rd_type  <= n_rd_type;
        r_rd_slot  <= n_rd_slot;
        r_ev_type  <= n_ev_type;
        r_ev_slot  <= n_ev_slot;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b0, r_out.count, r_out.elapsed, r_out.slot};
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // A slot under evaluation exists only during a scan
    a_ev_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> (r_state == S_SCAN))
        else $error("slot evaluation outside a scan");

    // The final beat of an input beat ends its processing
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_last) |=> (r_state == S_IDLE))
        else $error("block not idle after final beat");

    // Nothing stays pending once idle
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_vld)
        else $error("pending result left over in idle");

    // The ms counter moves only on an accepted tick
    a_now_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_now) |-> (!$past(i_rst_n) ||
                             ($past(in_acc) && ($past(s_axis_tuser) == FN_TICK))))
        else $error("ms counter changed without a tick");
`endif

endmodule

`default_nettype wire
